// ----- sv/rsa_pkg.sv -----
// Shared codes and constants for the row scatter-add accumulator.
package rsa_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ACC   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ROW_OOR = 2'd1;
  localparam logic [1:0] STAT_COL_OOR = 2'd2;

  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_HALF = 2'd2;

  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

endpackage

// ----- sv/rsa_fadd.sv -----
// Six-stage pipelined binary32 adder, round to nearest even, canonical NaN.
module rsa_fadd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        valid_o,
  output logic [31:0] sum_o
);

  logic [5:0] vld_q;

  // Stage 1: unpack, specials, order by magnitude.
  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [31:0] big, small_op;
  logic [7:0]  eb_eff, es_eff;
  logic        s1_nan_q, s1_inf_q, s1_infs_q, s1_sign_q, s1_sub_q;
  logic [7:0]  s1_exp_q, s1_diff_q;
  logic [23:0] s1_sigb_q, s1_sigs_q;

  always_comb begin
    a_nan = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    a_inf = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    swap = b_i[30:0] > a_i[30:0];
    big = swap ? b_i : a_i;
    small_op = swap ? a_i : b_i;
    eb_eff = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es_eff = (small_op[30:23] == 8'd0) ? 8'd1 : small_op[30:23];
  end

  always_ff @(posedge clk_i) begin
    s1_nan_q  <= a_nan | b_nan | (a_inf & b_inf & (a_i[31] ^ b_i[31]));
    s1_inf_q  <= a_inf | b_inf;
    s1_infs_q <= a_inf ? a_i[31] : b_i[31];
    s1_sign_q <= big[31];
    s1_sub_q  <= a_i[31] ^ b_i[31];
    s1_exp_q  <= eb_eff;
    s1_diff_q <= eb_eff - es_eff;
    s1_sigb_q <= {big[30:23] != 8'd0, big[22:0]};
    s1_sigs_q <= {small_op[30:23] != 8'd0, small_op[22:0]};
  end

  // Stage 2: align the smaller operand with a sticky bit.
  logic [26:0] sm_ext, sm_shift, sm_mask, aligned;
  logic        s2_nan_q, s2_inf_q, s2_infs_q, s2_sign_q, s2_sub_q;
  logic [7:0]  s2_exp_q;
  logic [23:0] s2_sigb_q;
  logic [26:0] s2_al_q;

  always_comb begin
    sm_ext = {s1_sigs_q, 3'b000};
    if (s1_diff_q >= 8'd27) begin
      sm_shift = 27'd0;
      sm_mask  = '1;
    end else begin
      sm_shift = sm_ext >> s1_diff_q[4:0];
      sm_mask  = ~(27'h7FF_FFFF << s1_diff_q[4:0]);
    end
    aligned = sm_shift | {26'd0, (sm_ext & sm_mask) != 27'd0};
  end

  always_ff @(posedge clk_i) begin
    s2_nan_q  <= s1_nan_q;
    s2_inf_q  <= s1_inf_q;
    s2_infs_q <= s1_infs_q;
    s2_sign_q <= s1_sign_q;
    s2_sub_q  <= s1_sub_q;
    s2_exp_q  <= s1_exp_q;
    s2_sigb_q <= s1_sigb_q;
    s2_al_q   <= aligned;
  end

  // Stage 3: magnitude add or subtract.
  logic        s3_nan_q, s3_inf_q, s3_infs_q, s3_sign_q, s3_sub_q;
  logic [7:0]  s3_exp_q;
  logic [27:0] s3_sum_q;

  always_ff @(posedge clk_i) begin
    s3_nan_q  <= s2_nan_q;
    s3_inf_q  <= s2_inf_q;
    s3_infs_q <= s2_infs_q;
    s3_sign_q <= s2_sign_q;
    s3_sub_q  <= s2_sub_q;
    s3_exp_q  <= s2_exp_q;
    s3_sum_q  <= s2_sub_q ? ({1'b0, s2_sigb_q, 3'b000} - {1'b0, s2_al_q})
                          : ({1'b0, s2_sigb_q, 3'b000} + {1'b0, s2_al_q});
  end

  // Stage 4: leading zero count below the carry bit.
  logic [4:0]  lz;
  logic        s4_nan_q, s4_inf_q, s4_infs_q, s4_sign_q, s4_sub_q;
  logic [7:0]  s4_exp_q;
  logic [27:0] s4_sum_q;
  logic [4:0]  s4_lz_q;

  always_comb begin
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (s3_sum_q[i]) lz = 5'(26 - i);
    end
  end

  always_ff @(posedge clk_i) begin
    s4_nan_q  <= s3_nan_q;
    s4_inf_q  <= s3_inf_q;
    s4_infs_q <= s3_infs_q;
    s4_sign_q <= s3_sign_q;
    s4_sub_q  <= s3_sub_q;
    s4_exp_q  <= s3_exp_q;
    s4_sum_q  <= s3_sum_q;
    s4_lz_q   <= lz;
  end

  // Stage 5: normalize, stopping at the subnormal boundary.
  logic [7:0]  max_sh, sh;
  logic [26:0] nsig;
  logic [8:0]  nexp;
  logic        s5_nan_q, s5_inf_q, s5_infs_q, s5_sign_q, s5_zero_q;
  logic [8:0]  s5_exp_q;
  logic [26:0] s5_sig_q;

  always_comb begin
    max_sh = s4_exp_q - 8'd1;
    sh = ({3'd0, s4_lz_q} < max_sh) ? {3'd0, s4_lz_q} : max_sh;
    if (s4_sum_q[27]) begin
      nsig = {s4_sum_q[27:2], s4_sum_q[1] | s4_sum_q[0]};
      nexp = {1'b0, s4_exp_q} + 9'd1;
    end else begin
      nsig = s4_sum_q[26:0] << sh;
      nexp = nsig[26] ? ({1'b0, s4_exp_q} - {1'b0, sh}) : 9'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_nan_q  <= s4_nan_q;
    s5_inf_q  <= s4_inf_q;
    s5_infs_q <= s4_infs_q;
    // An exact zero sum is +0 unless both operands were zeros of one sign.
    s5_sign_q <= (s4_sum_q == 28'd0) ? (s4_sign_q & ~s4_sub_q) : s4_sign_q;
    s5_zero_q <= s4_sum_q == 28'd0;
    s5_exp_q  <= nexp;
    s5_sig_q  <= nsig;
  end

  // Stage 6: round to nearest even and pack.
  logic        inc;
  logic [24:0] rmant;
  logic [8:0]  fexp;
  logic [22:0] frac;
  logic [31:0] res;

  always_comb begin
    inc   = s5_sig_q[2] & (s5_sig_q[1] | s5_sig_q[0] | s5_sig_q[3]);
    rmant = {1'b0, s5_sig_q[26:3]} + {24'd0, inc};
    fexp  = s5_exp_q;
    frac  = rmant[22:0];
    if (rmant[24]) begin
      fexp = s5_exp_q + 9'd1;
      frac = rmant[23:1];
    end else if ((s5_exp_q == 9'd0) && rmant[23]) begin
      fexp = 9'd1;
    end
    if (s5_nan_q) begin
      res = rsa_pkg::F32_QNAN;
    end else if (s5_inf_q) begin
      res = {s5_infs_q, 8'hFF, 23'd0};
    end else if (s5_zero_q) begin
      res = {s5_sign_q, 31'd0};
    end else if (fexp >= 9'd255) begin
      res = {s5_sign_q, 8'hFF, 23'd0};
    end else begin
      res = {s5_sign_q, fexp[7:0], frac};
    end
  end

  always_ff @(posedge clk_i) begin
    sum_o <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  assign valid_o = vld_q[5];

endmodule

// ----- sv/row_scatter_add_accumulator.sv -----
// Top level of the row scatter-add accumulator: table memory, control and format handling.
//
// The block holds a MAX_ROWS x MAX_COLS table of 32-bit floating-point
// accumulators in one synchronous memory (binary16 in the low half of each
// entry in half mode). Pulse start_i with an operation while busy_o is low;
// exactly one result beat follows on data_o and status_o, marked by done_o
// for a single cycle. The receiver cannot stall the result, so it must
// sample it in that cycle. An out-of-range item or an unused code is answered
// directly, a read after one memory read, an accumulate after a memory read,
// operand widening, six adder stages and write-back, and a clear after a
// sweep that writes zero to one entry per cycle. The same sweep runs after
// reset with busy_o high. Items are handled one at a time; the next one is
// accepted in the cycle its predecessor's result is shown. Configuration
// writes are always ready and should be issued only while the block is idle.
module row_scatter_add_accumulator #(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  row_i,
  input  logic [3:0]  col_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [31:0] data_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_ADD,
    ST_WAIT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [8:0] rows_q;
  logic [4:0] cols_q;
  logic       half_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 9'd256;
      cols_q <= 5'd16;
      half_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rsa_pkg::CFG_ROWS: rows_q <= cfg_data_i;
        rsa_pkg::CFG_COLS: cols_q <= cfg_data_i[4:0];
        rsa_pkg::CFG_HALF: half_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Widens binary16 to binary32 exactly.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] p;
    logic [9:0] ms;
    begin
      e = h[14:10];
      m = h[9:0];
      p = 4'd0;
      for (int i = 0; i < 10; i++) begin
        if (m[i]) p = 4'(i);
      end
      ms = m << (4'd10 - p);
      if (e == 5'd0) begin
        if (m == 10'd0) widen_half = {h[15], 31'd0};
        else widen_half = {h[15], 8'd103 + {4'd0, p}, ms, 13'd0};
      end else if (e == 5'd31) begin
        widen_half = {h[15], 8'hFF, m, 13'd0};
      end else begin
        widen_half = {h[15], {3'd0, e} + 8'd112, m, 13'd0};
      end
    end
  endfunction

  // Shifts right by sh (1 to 24) with round to nearest even.
  function automatic logic [23:0] round_shift(input logic [23:0] sig, input logic [4:0] sh);
    logic [23:0] q, rem, halfway;
    begin
      q       = sig >> sh;
      rem     = sig & ~(24'hFF_FFFF << sh);
      halfway = 24'd1 << (sh - 5'd1);
      if ((rem > halfway) || ((rem == halfway) && q[0])) q = q + 24'd1;
      round_shift = q;
    end
  endfunction

  // Rounds binary32 to binary16 with round to nearest even.
  function automatic logic [15:0] narrow_half(input logic [31:0] f);
    logic [15:0] sgn;
    logic [7:0]  e;
    logic [22:0] m;
    logic signed [9:0] ue;
    logic [9:0]  sh;
    logic [23:0] q;
    begin
      sgn = {f[31], 15'd0};
      e   = f[30:23];
      m   = f[22:0];
      ue  = $signed({2'b00, e}) - 10'sd127;
      sh  = 10'(-ue - 10'sd1);
      q   = '0;
      if (e == 8'hFF) begin
        narrow_half = (m != 23'd0) ? 16'h7E00 : (sgn | 16'h7C00);
      end else if (e == 8'd0) begin
        narrow_half = sgn;
      end else if (ue > 10'sd15) begin
        narrow_half = sgn | 16'h7C00;
      end else if (ue >= -10'sd14) begin
        q = round_shift({1'b0, m}, 5'd13);
        narrow_half = sgn | (({11'd0, 5'(ue + 10'sd15)} << 10) + q[15:0]);
      end else if (sh > 10'd24) begin
        narrow_half = sgn;
      end else begin
        q = round_shift({1'b1, m}, sh[4:0]);
        narrow_half = sgn | q[15:0];
      end
    end
  endfunction

  // Input decode.
  logic             accept, row_oor, col_oor, is_access;
  logic [AddrW-1:0] addr_in;

  assign busy_o    = state_q != ST_IDLE;
  assign accept    = start_i && !busy_o;
  assign row_oor   = ({10'd0, row_i} >= 18'(rows_q)) || ({10'd0, row_i} >= 18'(MAX_ROWS));
  assign col_oor   = ({8'd0, col_i} >= 12'(cols_q)) || ({8'd0, col_i} >= 12'(MAX_COLS));
  assign is_access = (op_i == rsa_pkg::OP_ACC) || (op_i == rsa_pkg::OP_READ);
  assign addr_in   = AddrW'(int'(row_i) * int'(MAX_COLS) + int'(col_i));

  // Table memory, one write and one registered read per cycle.
  logic [31:0]      mem [Depth];
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr;
  logic [31:0]      mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem[addr_in];
  end

  // Adder and write-back data.
  logic             add_valid, add_done;
  logic [31:0]      add_sum, wb_data;
  logic [AddrW-1:0] clr_cnt_q, addr_q;
  logic             clr_resp_q, is_acc_q;
  logic [31:0]      opa_q, opb_q, val_q;

  rsa_fadd u_fadd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (add_valid),
    .a_i     (opa_q),
    .b_i     (opb_q),
    .valid_o (add_done),
    .sum_o   (add_sum)
  );

  assign add_valid = state_q == ST_ADD;
  assign wb_data   = half_q ? {16'd0, narrow_half(add_sum)} : add_sum;

  always_comb begin
    mem_re    = accept && is_access && !row_oor && !col_oor;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = wb_data;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if ((state_q == ST_WAIT) && add_done) begin
      mem_we = 1'b1;
    end
  end

  // Control sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_cnt_q  <= '0;
      clr_resp_q <= 1'b0;
      addr_q     <= '0;
      is_acc_q   <= 1'b0;
      val_q      <= '0;
      opa_q      <= '0;
      opb_q      <= '0;
      done_o     <= 1'b0;
      data_o     <= '0;
      status_o   <= rsa_pkg::STAT_OK;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (clr_cnt_q == AddrW'(Depth - 1)) begin
            clr_cnt_q <= '0;
            state_q   <= ST_IDLE;
            // Only a clear command answers; the sweep after reset is silent.
            done_o    <= clr_resp_q;
            if (clr_resp_q) begin
              data_o   <= '0;
              status_o <= rsa_pkg::STAT_OK;
            end
          end else begin
            clr_cnt_q <= clr_cnt_q + AddrW'(1);
            done_o    <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            addr_q   <= addr_in;
            is_acc_q <= op_i == rsa_pkg::OP_ACC;
            val_q    <= value_i;
            if (op_i == rsa_pkg::OP_CLEAR) begin
              clr_resp_q <= 1'b1;
              state_q    <= ST_CLEAR;
              done_o     <= 1'b0;
            end else if (is_access && row_oor) begin
              done_o   <= 1'b1;
              data_o   <= '0;
              status_o <= rsa_pkg::STAT_ROW_OOR;
            end else if (is_access && col_oor) begin
              done_o   <= 1'b1;
              data_o   <= '0;
              status_o <= rsa_pkg::STAT_COL_OOR;
            end else if (is_access) begin
              state_q <= ST_RD;
              done_o  <= 1'b0;
            end else begin
              done_o   <= 1'b1;
              data_o   <= '0;
              status_o <= rsa_pkg::STAT_OK;
            end
          end else begin
            done_o <= 1'b0;
          end
        end
        ST_RD: begin
          if (is_acc_q) begin
            opa_q   <= half_q ? widen_half(mem_rdata_q[15:0]) : mem_rdata_q;
            opb_q   <= half_q ? widen_half(val_q[15:0]) : val_q;
            state_q <= ST_ADD;
            done_o  <= 1'b0;
          end else begin
            done_o   <= 1'b1;
            data_o   <= mem_rdata_q;
            status_o <= rsa_pkg::STAT_OK;
            state_q  <= ST_IDLE;
          end
        end
        ST_ADD: begin
          state_q <= ST_WAIT;
          done_o  <= 1'b0;
        end
        ST_WAIT: begin
          done_o <= add_done;
          if (add_done) begin
            data_o   <= wb_data;
            status_o <= rsa_pkg::STAT_OK;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          done_o  <= 1'b0;
        end
      endcase
    end
  end

endmodule
